/* rtl/core/kwmt_pkg.sv */
// Package for the k-way merge winner tree: sizes, node type and helpers.
`default_nettype none
package kwmt_pkg;

	// Block configuration.
	localparam int LANES    = 8;
	localparam int KEY_BITS = 64;

	// Fixed field widths of the words on the channels.
	localparam int LANE_FIELD_W = 3;
	localparam int KEY_FIELD_W  = 64;

	// Smallest power of two that holds n leaves, never below two.
	function automatic int pow2_ceil(input int n);
		int p;
		p = 2;
		while (p < n) begin
			p = p * 2;
		end
		return p;
	endfunction

	localparam int LEAVES     = pow2_ceil(LANES);
	localparam int LEVELS     = $clog2(LEAVES);
	localparam int LEAF_W     = LEVELS;
	localparam int NODES      = LEAVES - 1;
	localparam int IDX_W      = $clog2(2 * LEAVES - 1);
	localparam int NODE_IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// One tree entry: whether it holds a winner, and which lane.
	typedef struct packed {
		logic              valid;
		logic [LEAF_W-1:0] lane;
	} node_t;

endpackage
`default_nettype wire

/* rtl/core/kwmt_req_if.sv */
// Input channel of the winner tree: one head update per word.
`default_nettype none
interface kwmt_req_if;
	import kwmt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [LANE_FIELD_W-1:0] lane;
	logic [KEY_FIELD_W-1:0]  head_key;
	logic                    exhausted;

	modport source (output valid, output lane, output head_key, output exhausted,
		input ready);
	modport sink (input valid, input lane, input head_key, input exhausted,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/kwmt_rsp_if.sv */
// Output channel of the winner tree: the current winner per word.
`default_nettype none
interface kwmt_rsp_if;
	import kwmt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [LANE_FIELD_W-1:0] winner_lane;
	logic [KEY_FIELD_W-1:0]  winner_key;
	logic                    all_done;

	modport source (output valid, output winner_lane, output winner_key, output all_done,
		input ready);
	modport sink (input valid, input winner_lane, input winner_key, input all_done,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/kwmt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module kwmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/kwmt_engine.sv */
// Update engine: head key store, tree nodes and the leaf-to-root walk.
`default_nettype none
module kwmt_engine (
	input  wire logic    clk,
	input  wire logic    arst_n,
	kwmt_req_if.sink     req,
	kwmt_rsp_if.source   rsp
);
	import kwmt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]          state_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [IDX_W-1:0]    idx_q;
	logic [LEAVES-1:0]   live_q;
	node_t               tree_q [NODES];
	logic [KEY_BITS-1:0] root_key_q;

	// Path node and its key, carried up the tree.
	node_t               path_q;
	logic [KEY_BITS-1:0] path_key_q;

	// Compare stage registers.
	logic                  cmp_vld_s1;
	node_t                 sib_s1;
	logic                  path_left_s1;
	logic [NODE_IDX_W-1:0] parent_s1;

	// Output register.
	logic                    out_valid_q;
	logic [LANE_FIELD_W-1:0] out_lane_q;
	logic [KEY_FIELD_W-1:0]  out_key_q;
	logic                    out_done_q;

	logic                accept;
	logic                lane_ok;
	logic [LEAF_W-1:0]   req_leaf;
	logic [IDX_W-1:0]    sib_idx;
	logic [IDX_W-1:0]    parent_idx;
	node_t               sib_node;
	logic [KEY_BITS-1:0] sib_key;
	node_t               l_node;
	node_t               r_node;
	logic [KEY_BITS-1:0] l_key;
	logic [KEY_BITS-1:0] r_key;
	node_t               win_node;
	logic [KEY_BITS-1:0] win_key;
	logic                out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign lane_ok   = (32'(req.lane) < 32'(LANES));
	assign req_leaf  = LEAF_W'(req.lane);
	assign out_free  = !out_valid_q || rsp.ready;

	// Head keys live in RAM; each level reads the sibling's key.
	kwmt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (LEAVES)
	) u_keys (
		.clk   (clk),
		.we    (accept && lane_ok && !req.exhausted),
		.waddr (req_leaf),
		.wdata (req.head_key[KEY_BITS-1:0]),
		.raddr (sib_node.lane),
		.rdata (sib_key)
	);

	// Sibling of the current path position. Siblings are never on the
	// path, so they stay fixed while the walk rewrites path nodes.
	always_comb begin
		sib_idx    = idx_q[0] ? (idx_q + IDX_W'(1)) : (idx_q - IDX_W'(1));
		parent_idx = (idx_q - IDX_W'(1)) >> 1;
		if (sib_idx >= IDX_W'(NODES)) begin
			sib_node.lane  = LEAF_W'(sib_idx - IDX_W'(NODES));
			sib_node.valid = live_q[sib_node.lane];
		end else begin
			sib_node = tree_q[NODE_IDX_W'(sib_idx)];
		end
	end

	// Pick the smaller key; an empty side loses and the right side wins ties.
	always_comb begin
		l_node = path_left_s1 ? path_q : sib_s1;
		r_node = path_left_s1 ? sib_s1 : path_q;
		l_key  = path_left_s1 ? path_key_q : sib_key;
		r_key  = path_left_s1 ? sib_key : path_key_q;
		priority if (!l_node.valid) begin
			win_node = r_node;
			win_key  = r_key;
		end else if (!r_node.valid) begin
			win_node = l_node;
			win_key  = l_key;
		end else if (l_key < r_key) begin
			win_node = l_node;
			win_key  = l_key;
		end else begin
			win_node = r_node;
			win_key  = r_key;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			live_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				tree_q[i] <= '0;
			end
		end else begin
			cmp_vld_s1 <= (state_q == ST_WALK);
			// A new result replaces the one taken in the same cycle.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmp_vld_s1) begin
				tree_q[parent_s1] <= win_node;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lvl_q <= '0;
						if (lane_ok) begin
							live_q[req_leaf] <= !req.exhausted;
							state_q          <= ST_WALK;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_WALK: begin
					lvl_q <= lvl_q + LVL_W'(1);
					if (32'(lvl_q) == LEVELS - 1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the walk and the output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q        <= IDX_W'(NODES) + IDX_W'(req_leaf);
			path_q.valid <= !req.exhausted;
			path_q.lane  <= req_leaf;
			path_key_q   <= req.head_key[KEY_BITS-1:0];
		end
		if (state_q == ST_WALK) begin
			idx_q        <= parent_idx;
			sib_s1       <= sib_node;
			path_left_s1 <= idx_q[0];
			parent_s1    <= NODE_IDX_W'(parent_idx);
		end
		if (cmp_vld_s1) begin
			path_q     <= win_node;
			path_key_q <= win_key;
			if (parent_s1 == '0) begin
				root_key_q <= win_key;
			end
		end
		if ((state_q == ST_OUT) && out_free) begin
			if (tree_q[0].valid) begin
				out_lane_q <= LANE_FIELD_W'(tree_q[0].lane);
				out_key_q  <= KEY_FIELD_W'(root_key_q);
				out_done_q <= 1'b0;
			end else begin
				out_lane_q <= '0;
				out_key_q  <= '0;
				out_done_q <= 1'b1;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.winner_lane = out_lane_q;
	assign rsp.winner_key  = out_key_q;
	assign rsp.all_done    = out_done_q;

endmodule
`default_nettype wire

/* rtl/core/kway_merge_winner_tree.sv */
// Top level of the k-way merge winner tree.
`default_nettype none
// Winner tree over LANES sorted streams. Each request word replaces one lane's
// head key, or marks the lane exhausted, and the response word gives the lane
// and key of the smallest live head (right lane on ties), or all_done with zero
// fields when no lane is live. The tree starts empty; feed every lane once to
// build it. A word walks from acceptance to the result register one tree level
// per step, each step reading the sibling's key from the key RAM, then passes
// one compare drain and one output load. The next request word is taken only
// after the result is loaded, so no new word is accepted while one is in the
// walk; the output load waits while an untaken response word blocks the
// register. Request words with a lane at or above LANES leave the tree
// unchanged and return the current winner. The head key RAM needs no clearing
// after reset.
module kway_merge_winner_tree (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kwmt_req_if.sink   req,
	kwmt_rsp_if.source rsp
);

	kwmt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
